>>> design/mbk_pkg.sv
`default_nettype none
package mbk_pkg;

    // message store size, fixed by the two 64-bit character registers
    localparam int MAX_CHARS = 16;
    localparam logic [4:0] MAX_LEN = 5'(MAX_CHARS);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH   = 3'd6;

    // ASCII codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    localparam logic [4:0] NUM_LETTERS = 5'd26;

    // live settings from the register file
    typedef struct packed {
        logic [15:0]  dot_ticks;
        logic [15:0]  letter_gap_ticks;
        logic [15:0]  word_gap_ticks;
        logic         output_active_low;
        logic [4:0]   message_length;
        logic [127:0] chars;
    } mbk_cfg_t;

    // one result item
    typedef struct packed {
        logic [3:0] char_position;
        logic       keyed;
        logic       pin_level;
    } mbk_res_t;

    // Morse pattern: element count and dash mask (bit i set = element i is a dash)
    typedef struct packed {
        logic [2:0] len;
        logic [3:0] dashes;
    } mbk_code_t;

    function automatic mbk_code_t morse_lookup(input logic [4:0] code);
        mbk_code_t c;
        case (code)
            5'd0:    c = '{3'd2, 4'b0010};  // A .-
            5'd1:    c = '{3'd4, 4'b0001};  // B -...
            5'd2:    c = '{3'd4, 4'b0101};  // C -.-.
            5'd3:    c = '{3'd3, 4'b0001};  // D -..
            5'd4:    c = '{3'd1, 4'b0000};  // E .
            5'd5:    c = '{3'd4, 4'b0100};  // F ..-.
            5'd6:    c = '{3'd3, 4'b0011};  // G --.
            5'd7:    c = '{3'd4, 4'b0000};  // H ....
            5'd8:    c = '{3'd2, 4'b0000};  // I ..
            5'd9:    c = '{3'd4, 4'b1110};  // J .---
            5'd10:   c = '{3'd3, 4'b0101};  // K -.-
            5'd11:   c = '{3'd4, 4'b0010};  // L .-..
            5'd12:   c = '{3'd2, 4'b0011};  // M --
            5'd13:   c = '{3'd2, 4'b0001};  // N -.
            5'd14:   c = '{3'd3, 4'b0111};  // O ---
            5'd15:   c = '{3'd4, 4'b0110};  // P .--.
            5'd16:   c = '{3'd4, 4'b1011};  // Q --.-
            5'd17:   c = '{3'd3, 4'b0010};  // R .-.
            5'd18:   c = '{3'd3, 4'b0000};  // S ...
            5'd19:   c = '{3'd1, 4'b0001};  // T -
            5'd20:   c = '{3'd3, 4'b0100};  // U ..-
            5'd21:   c = '{3'd4, 4'b1000};  // V ...-
            5'd22:   c = '{3'd3, 4'b0110};  // W .--
            5'd23:   c = '{3'd4, 4'b1001};  // X -..-
            5'd24:   c = '{3'd4, 4'b1101};  // Y -.--
            5'd25:   c = '{3'd4, 4'b0011};  // Z --..
            default: c = '{3'd0, 4'b0000};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> design/mbk_cfg.sv
`default_nettype none
module mbk_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [mbk_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [63:0]                 wr_data,
    output mbk_pkg::mbk_cfg_t                cfg,
    output logic                             restart
);
    import mbk_pkg::*;

    logic [15:0]  dot_reg, dot_next;
    logic [15:0]  lgap_reg, lgap_next;
    logic [15:0]  wgap_reg, wgap_next;
    logic         alow_reg, alow_next;
    logic [4:0]   len_reg, len_next;
    logic [127:0] chars_reg, chars_next;

    // register write decode
    always_comb begin
        dot_next   = dot_reg;
        lgap_next  = lgap_reg;
        wgap_next  = wgap_reg;
        alow_next  = alow_reg;
        len_next   = len_reg;
        chars_next = chars_reg;
        restart    = 1'b0;
        if (wr_en) begin
            case (wr_index)
                REG_DOT_TICKS:  dot_next  = wr_data[15:0];
                REG_LETTER_GAP: lgap_next = wr_data[15:0];
                REG_WORD_GAP:   wgap_next = wr_data[15:0];
                REG_ACTIVE_LOW: alow_next = wr_data[0];
                REG_MSG_LEN: begin
                    len_next = (wr_data[4:0] > MAX_LEN) ? MAX_LEN : wr_data[4:0];
                    restart  = 1'b1;
                end
                REG_CHARS_LOW:  chars_next[63:0]   = wr_data;
                REG_CHARS_HIGH: chars_next[127:64] = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg   <= 16'd100;
            lgap_reg  <= 16'd900;
            wgap_reg  <= 16'd2100;
            alow_reg  <= 1'b1;
            len_reg   <= 5'd0;
            chars_reg <= '0;
        end else begin
            dot_reg   <= dot_next;
            lgap_reg  <= lgap_next;
            wgap_reg  <= wgap_next;
            alow_reg  <= alow_next;
            len_reg   <= len_next;
            chars_reg <= chars_next;
        end
    end

    assign cfg.dot_ticks         = dot_reg;
    assign cfg.letter_gap_ticks  = lgap_reg;
    assign cfg.word_gap_ticks    = wgap_reg;
    assign cfg.output_active_low = alow_reg;
    assign cfg.message_length    = len_reg;
    assign cfg.chars             = chars_reg;

endmodule
`default_nettype wire

>>> design/mbk_seq.sv
`default_nettype none
module mbk_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mbk_pkg::mbk_cfg_t cfg,
    input  wire logic              restart,
    input  wire logic              step,
    input  wire logic [15:0]       elapsed,
    output mbk_pkg::mbk_res_t      res
);
    import mbk_pkg::*;

    typedef struct packed {
        logic        lamp;
        logic        in_letter;
        logic [2:0]  elem;
        logic [15:0] on_cd;
        logic [16:0] chg_cd;
    } elem_res_t;

    // next element of a letter, or the letter gap when the letter is done
    function automatic elem_res_t next_elem(
        input logic [4:0]  code,
        input logic [2:0]  idx,
        input logic [15:0] dot,
        input logic [15:0] lgap,
        input logic [15:0] on_cd
    );
        mbk_code_t mc;
        logic [17:0] on_t;
        logic [18:0] per;
        elem_res_t   r;
        mc   = morse_lookup(code);
        on_t = {2'b00, dot};
        per  = '0;
        if (code < NUM_LETTERS && idx < mc.len) begin
            if (mc.dashes[idx[1:0]])
                on_t = {2'b00, dot} + {1'b0, dot, 1'b0};
            per         = {1'b0, on_t} + {3'b000, dot};
            r.lamp      = 1'b1;
            r.in_letter = 1'b1;
            r.elem      = idx + 3'd1;
            r.on_cd     = (on_t > 18'h0FFFF) ? 16'hFFFF : on_t[15:0];
            r.chg_cd    = (per > 19'h1FFFF) ? 17'h1FFFF : per[16:0];
        end else begin
            r.lamp      = 1'b0;
            r.in_letter = 1'b0;
            r.elem      = 3'd0;
            r.on_cd     = on_cd;
            r.chg_cd    = {1'b0, lgap};
        end
        return r;
    endfunction

    logic [3:0]  ci_reg, ci_next;
    logic        in_letter_reg, in_letter_next;
    logic [4:0]  code_reg, code_next;
    logic [2:0]  elem_reg, elem_next;
    logic        lamp_reg, lamp_next;
    logic [15:0] on_reg, on_next;
    logic [16:0] chg_reg, chg_next;
    logic        end_reg, end_next;

    logic [15:0] on_dec;
    logic [16:0] chg_dec;
    logic        lamp_dec;
    logic [7:0]  ch_raw, ch;
    logic [4:0]  ci_ext;
    elem_res_t   er_cur, er_new;

    // saturating countdowns
    assign on_dec   = (on_reg > elapsed) ? on_reg - elapsed : 16'd0;
    assign chg_dec  = (chg_reg > {1'b0, elapsed}) ? chg_reg - {1'b0, elapsed} : 17'd0;
    assign lamp_dec = lamp_reg && (on_dec != 16'd0);

    // character fetch with case folding
    assign ci_ext = {1'b0, ci_reg};
    assign ch_raw = cfg.chars[{ci_reg, 3'b000} +: 8];
    always_comb begin
        ch = ch_raw;
        if (ch_raw inside {[CH_LC_A:CH_LC_Z]})
            ch = ch_raw - CASE_DIFF;
    end

    assign er_cur = next_elem(code_reg, elem_reg, cfg.dot_ticks, cfg.letter_gap_ticks,
                              on_dec);
    assign er_new = next_elem(5'(ch - CH_UC_A), 3'd0, cfg.dot_ticks,
                              cfg.letter_gap_ticks, on_dec);

    // at most one keying action per item
    always_comb begin
        ci_next        = ci_reg;
        in_letter_next = in_letter_reg;
        code_next      = code_reg;
        elem_next      = elem_reg;
        lamp_next      = lamp_dec;
        on_next        = on_dec;
        chg_next       = chg_dec;
        end_next       = end_reg;
        if (chg_dec == 17'd0) begin
            if (in_letter_reg) begin
                in_letter_next = er_cur.in_letter;
                elem_next      = er_cur.elem;
                lamp_next      = er_cur.lamp;
                on_next        = er_cur.on_cd;
                chg_next       = er_cur.chg_cd;
            end else if (end_reg || ci_ext >= cfg.message_length) begin
                // end of message: double word gap, then wrap
                ci_next   = 4'd0;
                end_next  = 1'b0;
                lamp_next = 1'b0;
                chg_next  = {cfg.word_gap_ticks, 1'b0};
            end else begin
                ci_next  = ci_reg + 4'd1;
                end_next = end_reg || ((ci_ext + 5'd1) >= cfg.message_length);
                if (ch == CH_SPACE) begin
                    lamp_next = 1'b0;
                    chg_next  = {1'b0, cfg.word_gap_ticks};
                end else if (ch == CH_PERIOD) begin
                    lamp_next = 1'b0;
                    chg_next  = {cfg.word_gap_ticks, 1'b0};
                end else if (ch inside {[CH_UC_A:CH_UC_Z]}) begin
                    code_next      = 5'(ch - CH_UC_A);
                    in_letter_next = er_new.in_letter;
                    elem_next      = er_new.elem;
                    lamp_next      = er_new.lamp;
                    on_next        = er_new.on_cd;
                    chg_next       = er_new.chg_cd;
                end else begin
                    // unknown character: letter gap only
                    lamp_next = 1'b0;
                    chg_next  = {1'b0, cfg.letter_gap_ticks};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            ci_reg        <= 4'd0;
            in_letter_reg <= 1'b0;
            code_reg      <= 5'd0;
            elem_reg      <= 3'd0;
            lamp_reg      <= 1'b0;
            on_reg        <= 16'd0;
            chg_reg       <= 17'd0;
            end_reg       <= 1'b0;
        end else if (step) begin
            ci_reg        <= ci_next;
            in_letter_reg <= in_letter_next;
            code_reg      <= code_next;
            elem_reg      <= elem_next;
            lamp_reg      <= lamp_next;
            on_reg        <= on_next;
            chg_reg       <= chg_next;
            end_reg       <= end_next;
        end
    end

    assign res.char_position = ci_next;
    assign res.keyed         = lamp_next;
    assign res.pin_level     = lamp_next ^ cfg.output_active_low;

endmodule
`default_nettype wire

>>> design/morse_beacon_keyer.sv
// Pipeline: each item passes the input register, then the result register, and waits
//   in the result register only while m_tready holds it back.
// Throughput: one item per cycle when m_tready does not stall; keying is combinational.
// Reset: synchronous on aresetn low; registers return to defaults (dot 100, letter
//   gap 900, word gap 2100, active low, empty message), keying state clears.
`default_nettype none
module morse_beacon_keyer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] elapsed_ticks
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [0] pin_level, [1] keyed, [5:2] char_position
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import mbk_pkg::*;

    mbk_cfg_t    cfg;
    mbk_res_t    res;
    logic        restart;
    logic        advance;

    logic        in_valid_reg, in_valid_next;
    logic [15:0] in_ticks_reg;
    logic        out_valid_reg, out_valid_next;
    mbk_res_t    out_res_reg;

    assign cfg_ready = 1'b1;

    mbk_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .restart  (restart)
    );

    mbk_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .restart  (restart),
        .step     (advance),
        .elapsed  (in_ticks_reg),
        .res      (res)
    );

    // pipeline flow control
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_ticks_reg <= s_tdata;
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.char_position, out_res_reg.keyed,
                       out_res_reg.pin_level};

endmodule
`default_nettype wire

>>> design/mbk_checker.sv
`default_nettype none
module mbk_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    // a stalled result holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // with the result register empty, input is never held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // an item taken while the output is empty is followed by a valid result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
        else $error("result missing after accepted item");

    // padding bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("nonzero padding in result");

endmodule

bind morse_beacon_keyer mbk_checker u_mbk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
